/* design/chht_pkg.sv */
// ----------------------------------------------------------------------------
// Connection table package
// Shared types and constants for the peer connection table.
// ----------------------------------------------------------------------------
package chht_pkg;

  localparam int unsigned MaxPeersDefault = 8;

  // Input modes.
  localparam logic [2:0] ModeConnect    = 3'd0;
  localparam logic [2:0] ModeDisconnect = 3'd1;
  localparam logic [2:0] ModeReceive    = 3'd2;
  localparam logic [2:0] ModeTick       = 3'd3;
  localparam logic [2:0] ModeDataSent   = 3'd4;

  // Packet kinds.
  localparam logic [2:0] PktRequest    = 3'd0;
  localparam logic [2:0] PktAccept     = 3'd1;
  localparam logic [2:0] PktDisconnect = 3'd2;
  localparam logic [2:0] PktHeartbeat  = 3'd3;
  localparam logic [2:0] PktUser       = 3'd4;

  // Result actions.
  localparam logic [2:0] ActDone         = 3'd0;
  localparam logic [2:0] ActSend         = 3'd1;
  localparam logic [2:0] ActConnected    = 3'd2;
  localparam logic [2:0] ActDisconnected = 3'd3;
  localparam logic [2:0] ActDeliver      = 3'd4;
  localparam logic [2:0] ActId           = 3'd5;
  localparam logic [2:0] ActRefused      = 3'd6;

  // Entry phases.
  localparam logic [2:0] PhReq     = 3'd0;
  localparam logic [2:0] PhDecide  = 3'd1;
  localparam logic [2:0] PhConn    = 3'd2;
  localparam logic [2:0] PhDiscing = 3'd3;
  localparam logic [2:0] PhDisced  = 3'd4;
  localparam logic [2:0] PhFailed  = 3'd5;

  // Register indexes.
  localparam logic [2:0] RegIsServer  = 3'd0;
  localparam logic [2:0] RegRetry     = 3'd1;
  localparam logic [2:0] RegBeatIntv  = 3'd2;
  localparam logic [2:0] RegBeatTmo   = 3'd3;
  localparam logic [2:0] RegAttempts  = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [47:0] peer_address;
    logic [15:0] target_id;
    logic [2:0]  packet_kind;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  send_kind;
    logic [47:0] dest_address;
    logic [15:0] conn_id;
    logic        last;
  } out_word_t;

  // One table entry as held in memory.
  typedef struct packed {
    logic [2:0]  phase;
    logic [47:0] address;
    logic [15:0] id;
    logic [3:0]  attempts;
    logic [31:0] req_time;
    logic        req_sent;
    logic [31:0] beat_sent;
    logic [31:0] beat_heard;
    logic        accepted;
    logic        ever_conn;
  } entry_t;

endpackage

/* design/connection_handshake_heartbeat_table_core.sv */
// ----------------------------------------------------------------------------
// Connection table core
// Peer connection table with handshake, retries and heartbeat supervision.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid_i/in_stall_o; result words leave on
// out_valid_o/out_stall_i. Each input word produces its results followed by
// a closing done word with last set. Configuration registers are written
// through cfg_valid_i/cfg_ready_o; the user must do so only while the block
// is idle, as the block itself does not enforce it. The entries live in one
// synchronous memory with a registered read; valid bits are flip-flops.
// Every item other than a tick first scans the entries one at a time for its
// lookups, each in a read state and then a compare and write-back state, then
// decides; a found entry that is updated is read again and acted on, an id,
// refusal or deliver word goes out from a wait state, and the done word closes
// the item. A tick walks the entries, skipping free ones and reading then
// acting on used ones; a second word for an entry goes out from its own state.
// The output register holds a word while the receiver stalls; the engine
// waits on it, and the input side stays stalled until the item completes.
// Reset clears the valid bits, the id counter and the registers to their
// documented defaults; the memory contents need no clearing.
// ----------------------------------------------------------------------------
module connection_handshake_heartbeat_table_core #(
  parameter int unsigned MaxPeers = chht_pkg::MaxPeersDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  chht_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output chht_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int unsigned IdxW = (MaxPeers > 1) ? $clog2(MaxPeers) : 1;
  localparam int unsigned CntW = $clog2(MaxPeers + 1);
  localparam logic [CntW-1:0] LastIdx = CntW'(MaxPeers - 1);

  // Sequencer states.
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StScanR = 4'd1; // read entry for lookup
  localparam logic [3:0] StScanC = 4'd2; // compare entry
  localparam logic [3:0] StDecid = 4'd3; // decide after scan
  localparam logic [3:0] StRdTgt = 4'd4; // read target entry
  localparam logic [3:0] StActT  = 4'd5; // act on target entry
  localparam logic [3:0] StWalkR = 4'd6; // read for walk
  localparam logic [3:0] StWalkA = 4'd7; // act in walk
  localparam logic [3:0] StEmit2 = 4'd8; // second word of walk entry
  localparam logic [3:0] StDone  = 4'd9;
  localparam logic [3:0] StWait  = 4'd10; // emit single word then done

  // Configuration registers.
  logic        is_server_q;
  logic [15:0] retry_q, beat_intv_q, beat_tmo_q;
  logic [3:0]  attempts_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_server_q <= 1'b0;
      retry_q     <= 16'd1000;
      beat_intv_q <= 16'd1000;
      beat_tmo_q  <= 16'd5000;
      attempts_q  <= 4'd5;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        chht_pkg::RegIsServer: is_server_q <= cfg_data_i[0];
        chht_pkg::RegRetry:    retry_q     <= cfg_data_i;
        chht_pkg::RegBeatIntv: beat_intv_q <= cfg_data_i;
        chht_pkg::RegBeatTmo:  beat_tmo_q  <= cfg_data_i;
        chht_pkg::RegAttempts: attempts_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Entry memory, one read and one write port.
  chht_pkg::entry_t mem_q [MaxPeers];
  chht_pkg::entry_t rd_q;
  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  chht_pkg::entry_t wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[raddr];
  end

  // Control registers.
  logic [3:0]          st_q, st_d;
  logic [CntW-1:0]     idx_q, idx_d;
  chht_pkg::in_word_t  item_q, item_d;
  logic [MaxPeers-1:0] valid_q, valid_d;
  logic [15:0]         idc_q, idc_d;
  logic                hit_q, hit_d, free_q, free_d, done1_q, done1_d;
  logic [IdxW-1:0]     hidx_q, hidx_d, fidx_q, fidx_d;
  logic                ov_q, ov_d;
  chht_pkg::out_word_t ow_q, ow_d;
  chht_pkg::out_word_t pend_q, pend_d;

  assign in_stall_o  = (st_q != StIdle);
  assign out_valid_o = ov_q;
  assign out_word_o  = ow_q;

  logic [IdxW-1:0] cur;
  logic            oslot;
  logic [15:0]     nid;
  logic [31:0]     dt_req, dt_bs, dt_bh;

  assign cur    = idx_q[IdxW-1:0];
  assign oslot  = !ov_q || !out_stall_i;
  assign nid    = (idc_q == 16'hFFFF) ? 16'd1 : idc_q + 16'd1;
  assign dt_req = item_q.now_ms - rd_q.req_time;
  assign dt_bs  = item_q.now_ms - rd_q.beat_sent;
  assign dt_bh  = item_q.now_ms - rd_q.beat_heard;

  function automatic chht_pkg::out_word_t mk(logic [2:0] a, logic [2:0] k,
                                             logic [47:0] ad, logic [15:0] id);
    chht_pkg::out_word_t w;
    w.action = a; w.send_kind = k; w.dest_address = ad; w.conn_id = id; w.last = 1'b0;
    return w;
  endfunction

  always_comb begin
    chht_pkg::entry_t e;
    logic             match;
    logic             emitted;
    st_d = st_q; idx_d = idx_q; item_d = item_q; valid_d = valid_q; idc_d = idc_q;
    hit_d = hit_q; free_d = free_q; hidx_d = hidx_q; fidx_d = fidx_q;
    done1_d = done1_q; pend_d = pend_q;
    ov_d = ov_q && out_stall_i; ow_d = ow_q;
    we = 1'b0; waddr = cur; raddr = cur; wdata = rd_q; e = rd_q;
    match = 1'b0; emitted = 1'b0;

    case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d = in_word_i; idx_d = '0; hit_d = 1'b0; free_d = 1'b0;
          st_d = (in_word_i.mode == chht_pkg::ModeTick) ? StWalkR : StScanR;
        end
      end
      // Lookup scan: first valid match by address or id, first free slot.
      StScanR: begin
        raddr = cur;
        st_d = StScanC;
      end
      StScanC: begin
        if (!valid_q[cur]) begin
          if (!free_q) begin free_d = 1'b1; fidx_d = cur; end
        end else begin
          match = (item_q.mode == chht_pkg::ModeConnect ||
                   item_q.mode == chht_pkg::ModeReceive)
                  ? (rd_q.address == item_q.peer_address)
                  : (rd_q.id == item_q.target_id);
          if (match && !hit_q) begin hit_d = 1'b1; hidx_d = cur; end
          // Broadcast updates apply on the fly.
          if (item_q.mode == chht_pkg::ModeDisconnect &&
              (item_q.target_id == 16'd0 || !is_server_q)) begin
            e.phase = chht_pkg::PhDiscing; we = 1'b1; wdata = e;
          end
          if (item_q.mode == chht_pkg::ModeDataSent && item_q.target_id == 16'd0) begin
            e.beat_sent = item_q.now_ms; we = 1'b1; wdata = e;
          end
        end
        if (idx_q == LastIdx) st_d = StDecid;
        else begin idx_d = idx_q + CntW'(1); st_d = StScanR; end
      end
      StDecid: begin
        st_d = StDone;
        case (item_q.mode)
          chht_pkg::ModeConnect: begin
            if (is_server_q || hit_q || !free_q) begin
              pend_d = mk(chht_pkg::ActRefused, 3'd0, item_q.peer_address, 16'd0);
            end else begin
              idc_d = nid; valid_d[fidx_q] = 1'b1;
              e = '0; e.phase = chht_pkg::PhReq; e.address = item_q.peer_address;
              e.id = nid; e.attempts = attempts_q;
              we = 1'b1; waddr = fidx_q; wdata = e;
              pend_d = mk(chht_pkg::ActId, 3'd0, item_q.peer_address, nid);
            end
            st_d = StWait;
          end
          chht_pkg::ModeReceive: begin
            if (item_q.packet_kind == chht_pkg::PktRequest) begin
              if (!hit_q && is_server_q) begin
                if (!free_q) begin
                  pend_d = mk(chht_pkg::ActRefused, 3'd0, item_q.peer_address, 16'd0);
                end else begin
                  idc_d = nid; valid_d[fidx_q] = 1'b1;
                  e = '0; e.phase = chht_pkg::PhDecide; e.address = item_q.peer_address;
                  e.id = nid; e.beat_heard = item_q.now_ms;
                  we = 1'b1; waddr = fidx_q; wdata = e;
                  pend_d = mk(chht_pkg::ActId, 3'd0, item_q.peer_address, nid);
                end
                st_d = StWait;
              end
            end else if (hit_q) begin
              raddr = hidx_q; st_d = StRdTgt;
            end
          end
          chht_pkg::ModeDisconnect: begin
            if (hit_q && item_q.target_id != 16'd0 && is_server_q) begin
              raddr = hidx_q; st_d = StRdTgt;
            end
          end
          chht_pkg::ModeDataSent: begin
            if (hit_q && item_q.target_id != 16'd0) begin
              raddr = hidx_q; st_d = StRdTgt;
            end
          end
          default: ;
        endcase
      end
      StRdTgt: begin
        raddr = hidx_q; st_d = StActT;
      end
      StActT: begin
        waddr = hidx_q; st_d = StDone;
        if (item_q.mode == chht_pkg::ModeDisconnect) begin
          e.phase = chht_pkg::PhDiscing; we = 1'b1;
        end else if (item_q.mode == chht_pkg::ModeDataSent) begin
          e.beat_sent = item_q.now_ms; we = 1'b1;
        end else begin
          case (item_q.packet_kind)
            chht_pkg::PktAccept: begin
              if (rd_q.phase == chht_pkg::PhReq) begin
                e.accepted = 1'b1; e.beat_heard = item_q.now_ms; we = 1'b1;
              end
            end
            chht_pkg::PktDisconnect: begin
              e.phase = chht_pkg::PhDisced; we = 1'b1;
            end
            chht_pkg::PktHeartbeat: begin
              if (rd_q.phase == chht_pkg::PhReq) begin
                e.accepted = 1'b1; e.beat_heard = item_q.now_ms; we = 1'b1;
              end else if (rd_q.phase == chht_pkg::PhConn) begin
                e.beat_heard = item_q.now_ms; we = 1'b1;
              end
            end
            chht_pkg::PktUser: begin
              if (rd_q.phase == chht_pkg::PhConn) begin
                e.beat_heard = item_q.now_ms; we = 1'b1;
                pend_d = mk(chht_pkg::ActDeliver, 3'd0, item_q.peer_address, rd_q.id);
                st_d = StWait;
              end
            end
            default: ;
          endcase
        end
        wdata = e;
      end
      // Tick walk over every entry.
      StWalkR: begin
        if (idx_q == CntW'(MaxPeers)) st_d = StDone;
        else if (!valid_q[cur]) idx_d = idx_q + CntW'(1);
        else begin raddr = cur; st_d = StWalkA; end
      end
      StWalkA: begin
        if (oslot) begin
          done1_d = 1'b0;
          case (rd_q.phase)
            chht_pkg::PhReq: begin
              if (rd_q.accepted) begin
                e.phase = chht_pkg::PhConn; e.ever_conn = 1'b1;
                ow_d = mk(chht_pkg::ActConnected, 3'd0, rd_q.address, rd_q.id);
                emitted = 1'b1;
              end else if (!(rd_q.req_sent && dt_req < {16'd0, retry_q})) begin
                if (rd_q.attempts <= 4'd1) begin
                  e.attempts = 4'd0; e.phase = chht_pkg::PhFailed;
                end else begin
                  e.attempts = rd_q.attempts - 4'd1; e.req_time = item_q.now_ms;
                  e.req_sent = 1'b1;
                  ow_d = mk(chht_pkg::ActSend, chht_pkg::PktRequest, rd_q.address, rd_q.id);
                  emitted = 1'b1;
                end
              end
            end
            chht_pkg::PhDecide: begin
              e.beat_sent = item_q.now_ms; e.phase = chht_pkg::PhConn; e.ever_conn = 1'b1;
              ow_d = mk(chht_pkg::ActSend, chht_pkg::PktAccept, rd_q.address, rd_q.id);
              pend_d = mk(chht_pkg::ActConnected, 3'd0, rd_q.address, rd_q.id);
              emitted = 1'b1; done1_d = 1'b1;
            end
            chht_pkg::PhConn: begin
              if (dt_bs > {16'd0, beat_intv_q}) begin
                e.beat_sent = item_q.now_ms;
                ow_d = mk(chht_pkg::ActSend, chht_pkg::PktHeartbeat, rd_q.address, rd_q.id);
                emitted = 1'b1;
              end
              if (dt_bh > {16'd0, beat_tmo_q}) begin
                e.phase = chht_pkg::PhDisced;
                if (rd_q.ever_conn) begin
                  pend_d = mk(chht_pkg::ActDisconnected, 3'd0, rd_q.address, rd_q.id);
                  if (emitted) done1_d = 1'b1;
                  else begin ow_d = pend_d; emitted = 1'b1; end
                end
              end
            end
            chht_pkg::PhDiscing: begin
              e.phase = chht_pkg::PhDisced;
              ow_d = mk(chht_pkg::ActSend, chht_pkg::PktDisconnect, rd_q.address, rd_q.id);
              emitted = 1'b1;
              if (rd_q.ever_conn) begin
                pend_d = mk(chht_pkg::ActDisconnected, 3'd0, rd_q.address, rd_q.id);
                done1_d = 1'b1;
              end
            end
            chht_pkg::PhDisced: begin
              if (rd_q.ever_conn) begin
                ow_d = mk(chht_pkg::ActDisconnected, 3'd0, rd_q.address, rd_q.id);
                emitted = 1'b1;
              end
            end
            default: ;
          endcase
          if (e.phase == chht_pkg::PhDisced || e.phase == chht_pkg::PhFailed)
            valid_d[cur] = 1'b0;
          we = 1'b1; wdata = e;
          if (emitted) ov_d = 1'b1;
          if (done1_d) st_d = StEmit2;
          else begin idx_d = idx_q + CntW'(1); st_d = StWalkR; end
        end
      end
      StEmit2: begin
        if (oslot) begin
          ow_d = pend_q; ov_d = 1'b1; idx_d = idx_q + CntW'(1); st_d = StWalkR;
        end
      end
      StWait: begin
        if (oslot) begin
          ow_d = pend_q; ov_d = 1'b1; st_d = StDone;
        end
      end
      StDone: begin
        if (oslot) begin
          ow_d = mk(chht_pkg::ActDone, 3'd0, 48'd0, 16'd0);
          ow_d.last = 1'b1; ov_d = 1'b1; st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; idx_q <= '0; valid_q <= '0; idc_q <= '0;
      hit_q <= 1'b0; free_q <= 1'b0; done1_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; valid_q <= valid_d; idc_q <= idc_d;
      hit_q <= hit_d; free_q <= free_d; done1_q <= done1_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d; hidx_q <= hidx_d; fidx_q <= fidx_d;
    ow_q <= ow_d; pend_q <= pend_d;
  end

endmodule

/* sim/tb_checker.sv */
// ----------------------------------------------------------------------------
// Connection table checker
// Watches the input, result and register channels of the connection table,
// keeps its own copy of the table and compares every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_checker #(
  parameter int unsigned Peers = chht_pkg::MaxPeersDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  chht_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  chht_pkg::out_word_t out_word_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  // Register copies.
  logic        srv_mode;
  logic [15:0] retry_ms;
  logic [15:0] beat_intv_ms;
  logic [15:0] beat_tmo_ms;
  logic [3:0]  attempts_init;

  // Table copy.
  logic             used   [Peers];
  chht_pkg::entry_t table_q[Peers];
  logic [15:0]      id_seq;

  // Result words still to come, oldest first.
  chht_pkg::out_word_t owed_words[$];

  function automatic void owe(logic [2:0] act, logic [2:0] kind, logic [47:0] addr,
                              logic [15:0] id);
    chht_pkg::out_word_t w;
    w.action       = act;
    w.send_kind    = kind;
    w.dest_address = addr;
    w.conn_id      = id;
    w.last         = 1'b0;
    owed_words.insert(owed_words.size(), w);
  endfunction

  function automatic int slot_of_addr(logic [47:0] addr);
    for (int k = 0; k < Peers; k++)
      if (used[k] && table_q[k].address == addr) return k;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int k = 0; k < Peers; k++)
      if (!used[k]) return k;
    return -1;
  endfunction

  function automatic void open_slot(int k, logic [47:0] addr, logic [2:0] ph,
                                    logic [3:0] att);
    id_seq = id_seq + 16'd1;
    if (id_seq == 16'd0) id_seq = 16'd1;
    used[k]               = 1'b1;
    table_q[k].phase      = ph;
    table_q[k].address    = addr;
    table_q[k].id         = id_seq;
    table_q[k].attempts   = att;
    table_q[k].req_time   = '0;
    table_q[k].req_sent   = 1'b0;
    table_q[k].beat_sent  = '0;
    table_q[k].beat_heard = '0;
    table_q[k].accepted   = 1'b0;
    table_q[k].ever_conn  = 1'b0;
  endfunction

  function automatic void mark_connected(int k);
    table_q[k].phase     = chht_pkg::PhConn;
    table_q[k].ever_conn = 1'b1;
    owe(chht_pkg::ActConnected, chht_pkg::PktRequest, table_q[k].address, table_q[k].id);
  endfunction

  // One entry's share of a tick.
  function automatic void tick_slot(int k, logic [31:0] now);
    logic [47:0] a;
    logic [31:0] age;
    a = table_q[k].address;
    case (table_q[k].phase)
      chht_pkg::PhReq: begin
        age = now - table_q[k].req_time;
        if (table_q[k].accepted) begin
          mark_connected(k);
        end else if (!(table_q[k].req_sent && age < {16'd0, retry_ms})) begin
          if (table_q[k].attempts <= 4'd1) begin
            table_q[k].attempts = '0;
            table_q[k].phase    = chht_pkg::PhFailed;
          end else begin
            table_q[k].attempts = table_q[k].attempts - 4'd1;
            table_q[k].req_time = now;
            table_q[k].req_sent = 1'b1;
            owe(chht_pkg::ActSend, chht_pkg::PktRequest, a, table_q[k].id);
          end
        end
      end
      chht_pkg::PhDecide: begin
        owe(chht_pkg::ActSend, chht_pkg::PktAccept, a, table_q[k].id);
        table_q[k].beat_sent = now;
        mark_connected(k);
      end
      chht_pkg::PhConn: begin
        age = now - table_q[k].beat_sent;
        if (age > {16'd0, beat_intv_ms}) begin
          owe(chht_pkg::ActSend, chht_pkg::PktHeartbeat, a, table_q[k].id);
          table_q[k].beat_sent = now;
        end
        age = now - table_q[k].beat_heard;
        if (age > {16'd0, beat_tmo_ms}) table_q[k].phase = chht_pkg::PhDisced;
      end
      chht_pkg::PhDiscing: begin
        owe(chht_pkg::ActSend, chht_pkg::PktDisconnect, a, table_q[k].id);
        table_q[k].phase = chht_pkg::PhDisced;
      end
      default: ;
    endcase
    if (table_q[k].phase == chht_pkg::PhDisced) begin
      if (table_q[k].ever_conn)
        owe(chht_pkg::ActDisconnected, chht_pkg::PktRequest, a, table_q[k].id);
      used[k] = 1'b0;
    end else if (table_q[k].phase == chht_pkg::PhFailed) begin
      used[k] = 1'b0;
    end
  endfunction

  // A control packet from a peer.
  function automatic void take_packet(chht_pkg::in_word_t w);
    int k;
    int f;
    k = slot_of_addr(w.peer_address);
    case (w.packet_kind)
      chht_pkg::PktRequest: begin
        if (k < 0 && srv_mode) begin
          f = free_slot();
          if (f < 0) begin
            owe(chht_pkg::ActRefused, chht_pkg::PktRequest, w.peer_address, '0);
          end else begin
            open_slot(f, w.peer_address, chht_pkg::PhDecide, '0);
            table_q[f].beat_heard = w.now_ms;
            owe(chht_pkg::ActId, chht_pkg::PktRequest, w.peer_address, table_q[f].id);
          end
        end
      end
      chht_pkg::PktAccept: begin
        if (k >= 0 && table_q[k].phase == chht_pkg::PhReq) begin
          table_q[k].accepted   = 1'b1;
          table_q[k].beat_heard = w.now_ms;
        end
      end
      chht_pkg::PktDisconnect: begin
        if (k >= 0 && table_q[k].phase != chht_pkg::PhDisced)
          table_q[k].phase = chht_pkg::PhDisced;
      end
      chht_pkg::PktHeartbeat: begin
        if (k >= 0) begin
          if (table_q[k].phase == chht_pkg::PhReq) begin
            table_q[k].accepted   = 1'b1;
            table_q[k].beat_heard = w.now_ms;
          end else if (table_q[k].phase == chht_pkg::PhConn) begin
            table_q[k].beat_heard = w.now_ms;
          end
        end
      end
      chht_pkg::PktUser: begin
        if (k >= 0 && table_q[k].phase == chht_pkg::PhConn) begin
          owe(chht_pkg::ActDeliver, chht_pkg::PktRequest, w.peer_address, table_q[k].id);
          table_q[k].beat_heard = w.now_ms;
        end
      end
      default: ;
    endcase
  endfunction

  // Works out every word that one input word will produce.
  function automatic void predict_words(chht_pkg::in_word_t w);
    int  f;
    logic hit;
    chht_pkg::out_word_t fin;
    case (w.mode)
      chht_pkg::ModeConnect: begin
        f = free_slot();
        if (srv_mode || slot_of_addr(w.peer_address) >= 0 || f < 0) begin
          owe(chht_pkg::ActRefused, chht_pkg::PktRequest, w.peer_address, '0);
        end else begin
          open_slot(f, w.peer_address, chht_pkg::PhReq, attempts_init);
          owe(chht_pkg::ActId, chht_pkg::PktRequest, w.peer_address, table_q[f].id);
        end
      end
      chht_pkg::ModeDisconnect: begin
        hit = 1'b0;
        for (int k = 0; k < Peers; k++) begin
          if (w.target_id == '0 || !srv_mode) begin
            if (used[k]) table_q[k].phase = chht_pkg::PhDiscing;
          end else if (!hit && used[k] && table_q[k].id == w.target_id) begin
            table_q[k].phase = chht_pkg::PhDiscing;
            hit = 1'b1;
          end
        end
      end
      chht_pkg::ModeReceive: take_packet(w);
      chht_pkg::ModeTick: begin
        for (int k = 0; k < Peers; k++)
          if (used[k]) tick_slot(k, w.now_ms);
      end
      chht_pkg::ModeDataSent: begin
        hit = 1'b0;
        for (int k = 0; k < Peers; k++) begin
          if (!hit && used[k] && (w.target_id == '0 || table_q[k].id == w.target_id)) begin
            table_q[k].beat_sent = w.now_ms;
            if (w.target_id != '0) hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    fin = '0;
    fin.action = chht_pkg::ActDone;
    fin.last   = 1'b1;
    owed_words.insert(owed_words.size(), fin);
  endfunction

  // Follows the channels edge by edge.
  always @(posedge clk_i or negedge rst_ni) begin
    chht_pkg::out_word_t want;
    if (!rst_ni) begin
      srv_mode      <= 1'b0;
      retry_ms      <= 16'd1000;
      beat_intv_ms  <= 16'd1000;
      beat_tmo_ms   <= 16'd5000;
      attempts_init <= 4'd5;
      id_seq        = '0;
      for (int k = 0; k < Peers; k++) used[k] = 1'b0;
      owed_words.delete();
      fail_count_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          chht_pkg::RegIsServer: srv_mode      <= cfg_data_i[0];
          chht_pkg::RegRetry:    retry_ms      <= cfg_data_i;
          chht_pkg::RegBeatIntv: beat_intv_ms  <= cfg_data_i;
          chht_pkg::RegBeatTmo:  beat_tmo_ms   <= cfg_data_i;
          chht_pkg::RegAttempts: attempts_init <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_words(in_word_i);
      if (out_valid_i && !out_stall_i) begin
        if (owed_words.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: result word with none expected: %p", $realtime, out_word_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = owed_words.pop_front();
          if (out_word_i.action !== want.action || out_word_i.send_kind !== want.send_kind ||
              out_word_i.dest_address !== want.dest_address ||
              out_word_i.conn_id !== want.conn_id || out_word_i.last !== want.last) begin
            if (fail_count_o < 10)
              $display("%0t: mismatch expected %p got %p", $realtime, want, out_word_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= owed_words.size();
    end
  end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Connection table testbench
// Drives connects, packets, ticks and register settings into the table with
// random gaps and stalls; the checker beside the block judges every word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned PoolSize  = 10;
  localparam int unsigned IdleLimit = 4000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  chht_pkg::in_word_t  in_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b1;
  chht_pkg::out_word_t out_word_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i = '0;
  logic [15:0]         cfg_data_i = '0;

  int unsigned fail_count;
  int unsigned pending;
  logic        hold_request = 1'b0;
  logic        stim_quiet = 1'b0;
  logic [31:0] now_ms = '0;
  logic [47:0] pool[PoolSize];
  int unsigned idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  connection_handshake_heartbeat_table_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i, .out_valid_o,
    .out_stall_i, .out_word_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  tb_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_word_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Ends the run if nothing moves on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: random stalls per word, stretches without stalls, one long hold.
  initial begin
    int unsigned wait_n;
    int unsigned seen;
    logic        quiet;
    logic        held;
    seen  = 0;
    quiet = 1'b0;
    held  = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (seen % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
      wait_n = quiet ? 0 : $urandom_range(0, 15);
      if (hold_request && !held) begin
        wait_n = 400;
        held   = 1'b1;
      end
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      seen++;
      @(negedge clk_i);
    end
  end

  task automatic send_word(chht_pkg::in_word_t w);
    int unsigned gap;
    gap = stim_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    @(negedge clk_i);
  endtask

  task automatic send_fields(logic [2:0] mode, logic [47:0] addr, logic [15:0] tid,
                             logic [2:0] kind);
    chht_pkg::in_word_t w;
    w.mode         = mode;
    w.peer_address = addr;
    w.target_id    = tid;
    w.packet_kind  = kind;
    w.now_ms       = now_ms;
    send_word(w);
  endtask

  // Waits until every result word is in and the block has settled.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_registers(logic srv, logic [15:0] retry, logic [15:0] intv,
                               logic [15:0] tmo, logic [3:0] att);
    logic [15:0] vals[5];
    vals = '{{15'd0, srv}, retry, intv, tmo, {12'd0, att}};
    for (int r = 0; r < 5; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= r[2:0];
      cfg_data_i  <= vals[r];
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic fresh_pool();
    for (int p = 0; p < PoolSize; p++) pool[p] = 48'({$urandom(), $urandom()});
  endtask

  // One random word, mostly well-formed traffic around the address pool.
  task automatic random_word();
    int unsigned        pick;
    logic [47:0]        addr;
    chht_pkg::in_word_t w;
    pick = $urandom_range(0, 99);
    addr = pool[$urandom_range(0, PoolSize - 1)];
    case ($urandom_range(0, 9))
      0:       now_ms = now_ms + $urandom_range(3000, 70000);
      1:       now_ms = $urandom();
      default: now_ms = now_ms + $urandom_range(0, 1200);
    endcase
    if (pick < 30) begin
      send_fields(chht_pkg::ModeTick, addr, '0, chht_pkg::PktRequest);
    end else if (pick < 42) begin
      send_fields(chht_pkg::ModeConnect, addr, '0, chht_pkg::PktRequest);
    end else if (pick < 75) begin
      send_fields(chht_pkg::ModeReceive, addr, '0, 3'($urandom_range(0, 4)));
    end else if (pick < 82) begin
      send_fields(chht_pkg::ModeDisconnect, addr,
                  ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 120)),
                  chht_pkg::PktRequest);
    end else if (pick < 92) begin
      send_fields(chht_pkg::ModeDataSent, addr,
                  ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 120)),
                  chht_pkg::PktRequest);
    end else begin
      // Noise: anything the fields allow, unknown codes included.
      w.mode         = 3'($urandom());
      w.peer_address = ($urandom_range(0, 1) == 0) ? addr : 48'({$urandom(), $urandom()});
      w.target_id    = 16'($urandom());
      w.packet_kind  = 3'($urandom());
      w.now_ms       = now_ms;
      send_word(w);
    end
  endtask

  initial begin
    logic        srv[7]  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    logic [15:0] rt[7]   = '{16'd1000, 16'd0, 16'hFFFF, 16'd1000, 16'd0, 16'd300, 16'hFFFF};
    logic [15:0] hi[7]   = '{16'd1000, 16'd0, 16'hFFFF, 16'd500, 16'd2000, 16'd800, 16'd1000};
    logic [15:0] ht[7]   = '{16'd5000, 16'd0, 16'hFFFF, 16'd3000, 16'd4000, 16'd2500,
                             16'hFFFF};
    logic [3:0]  att[7]  = '{4'd5, 4'd1, 4'd15, 4'd3, 4'd1, 4'd0, 4'd2};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (40) @(negedge clk_i);

    for (int ph = 0; ph < 7; ph++) begin
      // The sender waits here until every expected word has come.
      drain();
      set_registers(srv[ph], rt[ph], hi[ph], ht[ph], att[ph]);
      fresh_pool();
      if (ph == 2) now_ms = 32'hFFFF_F000;

      if (ph == 0) begin
        // Directed: handshake, refusals, heartbeat, timeout, teardown.
        now_ms = 32'd100;
        send_fields(chht_pkg::ModeConnect, pool[0], '0, chht_pkg::PktRequest);
        send_fields(chht_pkg::ModeConnect, pool[0], '0, chht_pkg::PktRequest);
        send_fields(chht_pkg::ModeTick, '0, '0, chht_pkg::PktRequest);
        send_fields(chht_pkg::ModeTick, '0, '0, chht_pkg::PktRequest);
        now_ms = 32'd1500;
        send_fields(chht_pkg::ModeTick, '0, '0, chht_pkg::PktRequest);
        send_fields(chht_pkg::ModeReceive, pool[0], '0, chht_pkg::PktAccept);
        send_fields(chht_pkg::ModeTick, '0, '0, chht_pkg::PktRequest);
        send_fields(chht_pkg::ModeReceive, pool[0], '0, chht_pkg::PktUser);
        send_fields(chht_pkg::ModeDataSent, '0, 16'd1, chht_pkg::PktRequest);
        now_ms = 32'd20000;
        send_fields(chht_pkg::ModeTick, '0, '0, chht_pkg::PktRequest);
        send_fields(chht_pkg::ModeConnect, 48'hFFFF_FFFF_FFFF, '0, chht_pkg::PktRequest);
        send_fields(chht_pkg::ModeConnect, 48'h0, '0, chht_pkg::PktRequest);
        for (int p = 1; p < PoolSize; p++)
          send_fields(chht_pkg::ModeConnect, pool[p], '0, chht_pkg::PktRequest);
        send_fields(3'd7, pool[1], '0, chht_pkg::PktRequest);
        send_fields(chht_pkg::ModeReceive, pool[1], '0, 3'd7);
        send_fields(chht_pkg::ModeDataSent, '0, '0, chht_pkg::PktRequest);
        send_fields(chht_pkg::ModeDisconnect, '0, '0, chht_pkg::PktRequest);
        send_fields(chht_pkg::ModeTick, '0, '0, chht_pkg::PktRequest);
      end

      for (int n = 0; n < 28; n++) begin
        if (n % 10 == 0) stim_quiet = ($urandom_range(0, 3) == 0);
        // Long receiver hold while words keep coming in.
        if (ph == 3 && n == 4) hold_request = 1'b1;
        random_word();
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
